// ===== sv/tccc_pkg.sv =====
// shared types and constants for the text console cursor controller
// no dependencies; used by tccc_step and text_console_cursor_controller

package tccc_pkg;

    // glyph cell geometry in pixels, both powers of two
    localparam int GLYPH_WIDTH      = 8;
    localparam int GLYPH_HEIGHT     = 16;
    localparam int GW_SHIFT         = $clog2(GLYPH_WIDTH);
    localparam int GH_SHIFT         = $clog2(GLYPH_HEIGHT);

    // font range
    localparam int FIRST_GLYPH_CODE = 32;
    localparam int GLYPH_COUNT      = 96;

    // screen limits
    localparam logic [12:0] MAX_PIXELS = 13'd4096;
    localparam logic [12:0] MAX_COLS   = 13'd512;
    localparam logic [12:0] MAX_ROWS   = 13'd256;

    // tab stops every eight columns regardless of glyph size
    localparam int TAB_STOP = 8;

    // control characters
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_BS  = 8'h08;

    // configuration register indexes
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // reset values of the screen size registers
    localparam logic [12:0] RESET_WIDTH  = 13'd640;
    localparam logic [12:0] RESET_HEIGHT = 13'd480;

    typedef struct packed {
        logic [8:0] col;
        logic [7:0] row;
    } cursor_t;

    typedef struct packed {
        logic        marked;
        logic [11:0] left;
        logic [11:0] top;
        logic [12:0] span_x;
        logic [12:0] span_y;
    } box_t;

    // listed from the highest bit down so the packed form matches m_tdata
    typedef struct packed {
        logic [12:0] dirty_span_y;
        logic [12:0] dirty_span_x;
        logic [11:0] dirty_top;
        logic [11:0] dirty_left;
        logic        dirty_flag;
        logic [7:0]  cursor_row;
        logic [8:0]  cursor_col;
        logic        scroll_valid;
        logic [7:0]  draw_row;
        logic [8:0]  draw_col;
        logic [6:0]  glyph_index;
        logic        draw_valid;
    } result_t;

endpackage

// ===== sv/tccc_step.sv =====
// one character step: cursor movement, glyph request, scroll and dirty box merge
// depends on tccc_pkg

module tccc_step
(
    input  logic               console_enable,
    input  logic [12:0]        screen_width,
    input  logic [12:0]        screen_height,
    input  logic [7:0]         char_code,
    input  logic               display_held,
    input  logic               flush_after,
    input  tccc_pkg::cursor_t  cursor,
    input  tccc_pkg::box_t     box,
    output tccc_pkg::result_t  result,
    output tccc_pkg::cursor_t  cursor_next,
    output tccc_pkg::box_t     box_next
);

    logic [12:0] wpx;
    logic [12:0] hpx;
    logic [12:0] cols_raw;
    logic [12:0] rows_raw;
    logic [9:0]  cols;
    logic [8:0]  rows;
    logic        active;
    logic [9:0]  col_in;
    logic [8:0]  row_in;
    logic [9:0]  col_a;
    logic [8:0]  row_a;
    logic [9:0]  col_b;
    logic [8:0]  row_b;
    logic [8:0]  row_c;
    logic [8:0]  glyph_off;
    logic        in_font;
    logic        draw;
    logic        scroll;
    logic [13:0] x_full;
    logic [13:0] y_full;
    logic [11:0] cell_x;
    logic [11:0] cell_y;
    logic [11:0] left_new;
    logic [11:0] top_new;
    logic [13:0] end_x;
    logic [13:0] end_y;
    tccc_pkg::box_t box_a;
    tccc_pkg::box_t box_b;

    // clamp the screen size and derive the text grid
    assign wpx      = (screen_width  > tccc_pkg::MAX_PIXELS) ? tccc_pkg::MAX_PIXELS : screen_width;
    assign hpx      = (screen_height > tccc_pkg::MAX_PIXELS) ? tccc_pkg::MAX_PIXELS : screen_height;
    assign cols_raw = wpx >> tccc_pkg::GW_SHIFT;
    assign rows_raw = hpx >> tccc_pkg::GH_SHIFT;

    always_comb
    begin
        if (cols_raw > tccc_pkg::MAX_COLS)
            cols = tccc_pkg::MAX_COLS[9:0];
        else if (cols_raw == 13'd0)
            cols = 10'd1;
        else
            cols = cols_raw[9:0];

        if (rows_raw > tccc_pkg::MAX_ROWS)
            rows = tccc_pkg::MAX_ROWS[8:0];
        else if (rows_raw == 13'd0)
            rows = 9'd1;
        else
            rows = rows_raw[8:0];
    end

    assign active = console_enable && !display_held;
    assign col_in = {1'b0, cursor.col};
    assign row_in = {1'b0, cursor.row};

    // font range check on the raw code
    assign glyph_off = {1'b0, char_code} - 9'(tccc_pkg::FIRST_GLYPH_CODE);
    assign in_font   = !glyph_off[8] && (glyph_off < 9'(tccc_pkg::GLYPH_COUNT));

    // cursor movement for control codes and printable characters
    always_comb
    begin
        col_a = col_in;
        row_a = row_in;
        draw  = 1'b0;
        unique case (char_code)
            tccc_pkg::CHAR_LF:
            begin
                col_a = 10'd0;
                row_a = row_in + 9'd1;
            end
            tccc_pkg::CHAR_CR:
                col_a = 10'd0;
            tccc_pkg::CHAR_TAB:
                col_a = (col_in + 10'(tccc_pkg::TAB_STOP)) & ~10'(tccc_pkg::TAB_STOP - 1);
            tccc_pkg::CHAR_BS:
            begin
                if (col_in != 10'd0)
                    col_a = col_in - 10'd1;
            end
            default:
            begin
                draw  = in_font && (col_in < cols) && (row_in < rows);
                col_a = col_in + 10'd1;
            end
        endcase
    end

    // wrap at the column count, scroll past the last row
    always_comb
    begin
        if (col_a >= cols)
        begin
            col_b = 10'd0;
            row_b = row_a + 9'd1;
        end
        else
        begin
            col_b = col_a;
            row_b = row_a;
        end
        scroll = (row_b >= rows);
        row_c  = scroll ? (rows - 9'd1) : row_b;
    end

    // pixel rectangle of the drawn cell
    assign x_full = {4'b0, col_in} << tccc_pkg::GW_SHIFT;
    assign y_full = {5'b0, row_in} << tccc_pkg::GH_SHIFT;
    assign cell_x = x_full[11:0];
    assign cell_y = y_full[11:0];
    assign left_new = (cell_x < box.left) ? cell_x : box.left;
    assign top_new  = (cell_y < box.top)  ? cell_y : box.top;
    assign end_x    = {2'b0, cell_x} + 14'(tccc_pkg::GLYPH_WIDTH);
    assign end_y    = {2'b0, cell_y} + 14'(tccc_pkg::GLYPH_HEIGHT);

    // merge the glyph cell; the span compare uses the updated corner
    always_comb
    begin
        box_a = box;
        if (draw)
        begin
            box_a.marked = 1'b1;
            if (box.span_x == 13'd0)
            begin
                box_a.left   = cell_x;
                box_a.top    = cell_y;
                box_a.span_x = 13'(tccc_pkg::GLYPH_WIDTH);
                box_a.span_y = 13'(tccc_pkg::GLYPH_HEIGHT);
            end
            else
            begin
                box_a.left = left_new;
                box_a.top  = top_new;
                if (end_x > ({2'b0, left_new} + {1'b0, box.span_x}))
                    box_a.span_x = 13'(end_x - {2'b0, left_new});
                if (end_y > ({2'b0, top_new} + {1'b0, box.span_y}))
                    box_a.span_y = 13'(end_y - {2'b0, top_new});
            end
        end
    end

    // a scroll leaves the whole screen dirty, or nothing for an empty screen
    always_comb
    begin
        box_b = box_a;
        if (scroll)
        begin
            if ((wpx == 13'd0) || (hpx == 13'd0))
            begin
                box_b.marked = 1'b0;
                box_b.span_x = 13'd0;
            end
            else
            begin
                box_b.marked = 1'b1;
                box_b.left   = 12'd0;
                box_b.top    = 12'd0;
                box_b.span_x = wpx;
                box_b.span_y = hpx;
            end
        end
    end

    // state after this item; flush empties the box once it is reported
    always_comb
    begin
        tccc_pkg::box_t box_rep;
        box_rep = active ? box_b : box;
        if (active)
        begin
            cursor_next.col = col_b[8:0];
            cursor_next.row = row_c[7:0];
        end
        else
        begin
            cursor_next = cursor;
        end

        box_next = box_rep;
        if (console_enable && flush_after)
        begin
            box_next.marked = 1'b0;
            box_next.span_x = 13'd0;
        end

        result.draw_valid   = active && draw;
        result.glyph_index  = (active && draw) ? glyph_off[6:0] : 7'd0;
        result.draw_col     = (active && draw) ? col_in[8:0] : 9'd0;
        result.draw_row     = (active && draw) ? row_in[7:0] : 8'd0;
        result.scroll_valid = active && scroll;
        result.cursor_col   = cursor_next.col;
        result.cursor_row   = cursor_next.row;
        result.dirty_flag   = box_rep.marked;
        result.dirty_left   = box_rep.left;
        result.dirty_top    = box_rep.top;
        result.dirty_span_x = box_rep.span_x;
        result.dirty_span_y = box_rep.span_y;
    end

endmodule

// ===== sv/text_console_cursor_controller.sv =====
// text console cursor controller: input register, combinational step, result register
// depends on tccc_pkg and tccc_step
// an accepted input beat is held in the input register, stepped, then held in the result register
// throughput: one character per cycle while m_tready does not stall; the cursor and dirty box update with each step
// reset: cursor and dirty box cleared, console disabled, screen 640 by 480 pixels
// no clearing pass; the block accepts beats from the first cycle after reset

module text_console_cursor_controller
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_code, [8] display_held, [9] flush_after, [15:10] zero
    input  logic [15:0] s_tdata,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] draw_valid, [7:1] glyph_index, [16:8] draw_col, [24:17] draw_row,
    // [25] scroll_valid, [34:26] cursor_col, [42:35] cursor_row, [43] dirty_flag,
    // [55:44] dirty_left, [67:56] dirty_top, [80:68] dirty_span_x,
    // [93:81] dirty_span_y, [95:94] zero
    output logic [95:0] m_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    logic               enable_reg;
    logic [12:0]        width_reg;
    logic [12:0]        height_reg;

    logic               in_valid_reg;
    logic [7:0]         char_reg;
    logic               held_reg;
    logic               flush_reg;

    logic               out_valid_reg;
    tccc_pkg::result_t  out_res_reg;

    tccc_pkg::cursor_t  cursor_reg;
    tccc_pkg::box_t     box_reg;

    tccc_pkg::result_t  step_res;
    tccc_pkg::cursor_t  cursor_next;
    tccc_pkg::box_t     box_next;

    logic               advance;
    logic               step_fire;

    // pipeline moves when the result register is free or being drained
    assign advance   = !out_valid_reg || m_tready;
    assign step_fire = advance && in_valid_reg;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            width_reg  <= tccc_pkg::RESET_WIDTH;
            height_reg <= tccc_pkg::RESET_HEIGHT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tccc_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                tccc_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                tccc_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            char_reg  <= s_tdata[7:0];
            held_reg  <= s_tdata[8];
            flush_reg <= s_tdata[9];
        end
    end

    tccc_step u_step
    (
        .console_enable (enable_reg),
        .screen_width   (width_reg),
        .screen_height  (height_reg),
        .char_code      (char_reg),
        .display_held   (held_reg),
        .flush_after    (flush_reg),
        .cursor         (cursor_reg),
        .box            (box_reg),
        .result         (step_res),
        .cursor_next    (cursor_next),
        .box_next       (box_next)
    );

    // cursor and dirty box state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            box_reg    <= '0;
        end
        else if (step_fire)
        begin
            cursor_reg <= cursor_next;
            box_reg    <= box_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_fire)
            out_res_reg <= step_res;
    end

    // state only changes when an item is stepped
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_fire |=> $stable(cursor_reg) && $stable(box_reg))
        else $error("cursor or box changed without a stepped item");

    // reported cursor matches the stored cursor right after a step
    a_cursor_match: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> out_valid_reg && (out_res_reg.cursor_col == cursor_reg.col)
                      && (out_res_reg.cursor_row == cursor_reg.row))
        else $error("reported cursor differs from stored cursor");

    // a marked box always has a width, an unmarked one never does
    a_box_marked: assert property (@(posedge clk) disable iff (!rst_n)
        box_reg.marked == (box_reg.span_x != 13'd0))
        else $error("dirty box mark and width disagree");

    // a glyph request stays inside the font
    a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.draw_valid
            |-> out_res_reg.glyph_index < 7'(tccc_pkg::GLYPH_COUNT - 1) + 7'd1
                || tccc_pkg::GLYPH_COUNT == 128)
        else $error("glyph index beyond font");

endmodule
